// ----- design/gsdb_pkg.sv -----
// ----------------------------------------------------------------------------
// gsdb_pkg
// Shared types and constants for the gyro step detector and batcher.
// ----------------------------------------------------------------------------
package gsdb_pkg;

    // Field widths
    localparam int RATE_W   = 16;
    localparam int TEMP_W   = 16;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 11;
    localparam int IVL_W    = 16;
    localparam int PER_W    = 16;
    localparam int SWING_W  = 18;   // 4 * |rate_y - rate_z|
    localparam int LIMIT_W  = 19;   // threshold * 131
    localparam int STEPS_W  = 32;
    localparam int NUM_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Swing in deg/s is 4*|d| / 131
    localparam logic [7:0] SWING_DIV = 8'd131;

    // floor(x / 131) = (x * SWING_RECIP) >> RECIP_SHIFT for x below 2^18
    localparam int          RECIP_SHIFT = 25;
    localparam int          RECIP_W     = 18;
    localparam logic [17:0] SWING_RECIP = 18'd256141;
    localparam int          PROD_W      = SWING_W + RECIP_W;

    // Register reset values
    localparam logic [THR_W-1:0] RISE_RST  = 11'd175;
    localparam logic [THR_W-1:0] FALL_RST  = 11'd75;
    localparam logic [IVL_W-1:0] MIN_RST   = 16'd250;
    localparam logic [IVL_W-1:0] MAX_RST   = 16'd2500;
    localparam logic [IVL_W-1:0] FLUSH_RST = 16'd2500;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISE_THR  = 3'd0,
        CFG_FALL_THR  = 3'd1,
        CFG_MIN_IVL   = 3'd2,
        CFG_MAX_IVL   = 3'd3,
        CFG_FLUSH_TMO = 3'd4
    } cfg_index_t;

    // One stored step slot
    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [THR_W-1:0] intensity;
    } slot_t;

    // Slot write request into the batch memory
    typedef struct packed {
        logic  en;
        logic  bank;
        slot_t slot;
    } slot_wr_t;

    // Batch launch request
    typedef struct packed {
        logic [NUM_W-1:0]  start_number;
        logic [TEMP_W-1:0] temperature;
        logic              partial;
        logic              bank;
    } batch_desc_t;

endpackage

// ----- design/gsdb_emitter.sv -----
// ----------------------------------------------------------------------------
// gsdb_emitter
// Double-banked step slot memory and batch readout onto the result channel.
// ----------------------------------------------------------------------------
module gsdb_emitter #(
    parameter int BATCH_SLOTS = 5
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  gsdb_pkg::slot_wr_t                      wr,
    input  logic [((BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1)-1:0] wr_idx,
    input  logic                                    start_batch,
    input  gsdb_pkg::batch_desc_t                   desc,
    input  logic [$clog2(BATCH_SLOTS+1)-1:0]        desc_fill,
    output logic                                    busy,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [gsdb_pkg::NUM_W-1:0]              m_first_step_number,
    output logic [gsdb_pkg::PER_W-1:0]              m_slot_period,
    output logic [gsdb_pkg::THR_W-1:0]              m_slot_intensity,
    output logic signed [gsdb_pkg::TEMP_W-1:0]      m_batch_temperature,
    output logic                                    m_partial_batch,
    output logic                                    m_last_of_batch
);
    import gsdb_pkg::*;

    localparam int CW    = $clog2(BATCH_SLOTS + 1);
    localparam int DEPTH = 2 * BATCH_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] LAST_K = CW'(BATCH_SLOTS - 1);
    localparam logic [AW-1:0] BANK_OFS = AW'(BATCH_SLOTS);

    slot_t             mem [DEPTH];

    logic              busy_reg;
    logic [CW-1:0]     k_reg;
    batch_desc_t       desc_reg;
    logic [CW-1:0]     fill_reg;

    logic              m_valid_reg;
    slot_t             rd_reg;
    logic              used_reg;
    logic              last_reg;
    logic              partial_reg;
    logic [NUM_W-1:0]  start_reg;
    logic [TEMP_W-1:0] temp_reg;

    logic              issue;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    // Map bank and slot index onto the memory
    assign wr_addr = wr.bank ? (AW'(wr_idx) + BANK_OFS) : AW'(wr_idx);
    assign rd_addr = desc_reg.bank ? (AW'(k_reg) + BANK_OFS) : AW'(k_reg);

    // Read one slot whenever the output stage is free
    assign issue = busy_reg && (!m_valid_reg || m_ready);

    // Slot memory: write from the detector, read for the readout
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.slot;
        end
        if (issue) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Readout control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
                if (k_reg == LAST_K) begin
                    k_reg    <= '0;
                    busy_reg <= 1'b0;
                end else begin
                    k_reg <= k_reg + CW'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (start_batch) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
        end
    end

    // Batch descriptor: hold for the whole readout
    always_ff @(posedge aclk) begin
        if (start_batch) begin
            desc_reg <= desc;
            fill_reg <= desc_fill;
        end
    end

    // Output payload registers
    always_ff @(posedge aclk) begin
        if (issue) begin
            used_reg    <= (k_reg < fill_reg);
            last_reg    <= (k_reg == LAST_K);
            partial_reg <= desc_reg.partial;
            start_reg   <= desc_reg.start_number;
            temp_reg    <= desc_reg.temperature;
        end
    end

    // Drive the result channel; padded slots read as zero
    assign busy                = busy_reg;
    assign m_valid             = m_valid_reg;
    assign m_first_step_number = start_reg;
    assign m_slot_period       = used_reg ? rd_reg.period : '0;
    assign m_slot_intensity    = used_reg ? rd_reg.intensity : '0;
    assign m_batch_temperature = temp_reg;
    assign m_partial_batch     = partial_reg;
    assign m_last_of_batch     = last_reg;

endmodule

// ----- design/gyro_step_detector_batcher.sv -----
// ----------------------------------------------------------------------------
// gyro_step_detector_batcher
// Step detection with hysteresis on the gyro swing, step batching into slots
// and batch emission when full or after an idle timeout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  s_      | in        | s_valid / s_ready     | rate_y, rate_z, temperature_sample, time_ms
//  m_      | out       | m_valid / m_ready     | one slot of a batch per request
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (register write)
//
//  A sample is registered when accepted; samples may follow every cycle while s_ready stays high.
//  A batch leaves as BATCH_SLOTS requests, one per cycle while m_ready is high, read from the
//  single read port of the slot memory, which holds two banks of slots.
//  A sample that would launch a batch waits while the previous batch is
//  still being read out; other samples pass meanwhile.
//  Reset is synchronous; the slot memory is not cleared.
//  Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module gyro_step_detector_batcher #(
    parameter int BATCH_SLOTS = 5
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Sample input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gsdb_pkg::RATE_W-1:0]    s_rate_y,
    input  logic signed [gsdb_pkg::RATE_W-1:0]    s_rate_z,
    input  logic signed [gsdb_pkg::TEMP_W-1:0]    s_temperature_sample,
    input  logic [gsdb_pkg::TIME_W-1:0]           s_time_ms,
    // Batch output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [gsdb_pkg::NUM_W-1:0]            m_first_step_number,
    output logic [gsdb_pkg::PER_W-1:0]            m_slot_period,
    output logic [gsdb_pkg::THR_W-1:0]            m_slot_intensity,
    output logic signed [gsdb_pkg::TEMP_W-1:0]    m_batch_temperature,
    output logic                                  m_partial_batch,
    output logic                                  m_last_of_batch,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gsdb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gsdb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gsdb_pkg::*;

    localparam int IW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
    localparam int CW = $clog2(BATCH_SLOTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(BATCH_SLOTS);

    // Configuration registers
    logic [THR_W-1:0]   rise_reg;
    logic [THR_W-1:0]   fall_reg;
    logic [IVL_W-1:0]   min_reg;
    logic [IVL_W-1:0]   max_reg;
    logic [IVL_W-1:0]   flush_reg;

    // Detector state
    logic               lock_reg;
    logic               lock_next;
    logic [STEPS_W-1:0] total_reg;
    logic [STEPS_W-1:0] total_next;
    logic [TIME_W-1:0]  stamp_reg;
    logic [TIME_W-1:0]  stamp_next;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [NUM_W-1:0]   start_reg;
    logic [NUM_W-1:0]   start_next;
    logic               bank_reg;

    // Sample datapath
    logic signed [RATE_W:0] diff;
    logic [RATE_W-1:0]  mag;
    logic [SWING_W-1:0] swing;
    logic [LIMIT_W-1:0] rise_lim;
    logic [LIMIT_W-1:0] fall_lim;
    logic               over_rise;
    logic               under_fall;
    logic [PROD_W-1:0]  recip_prod;
    logic [THR_W-1:0]   intensity;
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  idle;
    logic               in_window;
    logic               edge_det;
    logic               count_step;
    logic               restart;
    logic [STEPS_W-1:0] total_inc;
    logic [CW-1:0]      fill_inc;
    logic               full;
    logic               timeout;
    logic               emit_now;
    logic               accept;
    logic               emit_busy;

    slot_wr_t           slot_wr;
    batch_desc_t        desc;

    // Swing magnitude, four times |rate_y - rate_z|
    assign diff  = {s_rate_y[RATE_W-1], s_rate_y} - {s_rate_z[RATE_W-1], s_rate_z};
    assign mag   = diff[RATE_W] ? RATE_W'(-diff) : diff[RATE_W-1:0];
    assign swing = {mag, 2'b00};

    // Thresholds scaled by 131
    assign rise_lim   = LIMIT_W'(rise_reg) * LIMIT_W'(SWING_DIV);
    assign fall_lim   = LIMIT_W'(fall_reg) * LIMIT_W'(SWING_DIV);
    assign over_rise  = LIMIT_W'(swing) > rise_lim;
    assign under_fall = LIMIT_W'(swing) < fall_lim;

    // Intensity in deg/s by reciprocal multiplication
    assign recip_prod = PROD_W'(swing) * PROD_W'(SWING_RECIP);
    assign intensity  = recip_prod[RECIP_SHIFT +: THR_W];

    // Step timing
    assign dt        = s_time_ms - stamp_reg;
    assign in_window = (dt >= TIME_W'(min_reg)) && (dt <= TIME_W'(max_reg));
    assign edge_det  = over_rise && !lock_reg;
    assign count_step = edge_det && (in_window || (total_reg == '0));
    assign restart   = edge_det && !count_step && (dt > TIME_W'(max_reg));

    // Next detector state
    always_comb begin
        total_inc  = total_reg + STEPS_W'(1);
        fill_inc   = fill_reg + CW'(1);
        lock_next  = edge_det ? 1'b1 : (under_fall ? 1'b0 : lock_reg);
        total_next = count_step ? total_inc : total_reg;
        start_next = (count_step && (fill_reg == '0)) ? total_inc[NUM_W-1:0] : start_reg;
        stamp_next = (count_step || restart) ? s_time_ms : stamp_reg;
        fill_next  = count_step ? fill_inc : fill_reg;
        full       = count_step && (fill_inc == FULL_CNT);
        idle       = s_time_ms - stamp_next;
        timeout    = !full && (fill_next != '0) && (idle > TIME_W'(flush_reg));
        emit_now   = full || timeout;
    end

    // Hold a launching sample while the previous batch is still read out
    assign s_ready = !emit_busy || !emit_now;
    assign accept  = s_valid && s_ready;

    // Slot write and batch launch requests
    always_comb begin
        slot_wr.en             = accept && count_step;
        slot_wr.bank           = bank_reg;
        slot_wr.slot.period    = dt[PER_W-1:0];
        slot_wr.slot.intensity = intensity;
        desc.start_number      = start_next;
        desc.temperature       = s_temperature_sample;
        desc.partial           = timeout;
        desc.bank              = bank_reg;
    end

    // Advance detector state on each accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg  <= 1'b0;
            total_reg <= '0;
            stamp_reg <= '0;
            fill_reg  <= '0;
            start_reg <= '0;
            bank_reg  <= 1'b0;
        end else if (accept) begin
            lock_reg  <= lock_next;
            total_reg <= total_next;
            stamp_reg <= stamp_next;
            start_reg <= start_next;
            fill_reg  <= emit_now ? '0 : fill_next;
            if (emit_now) begin
                bank_reg <= !bank_reg;
            end
        end
    end

    // Configuration register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg  <= RISE_RST;
            fall_reg  <= FALL_RST;
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
            flush_reg <= FLUSH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RISE_THR:  rise_reg  <= cfg_data[THR_W-1:0];
                CFG_FALL_THR:  fall_reg  <= cfg_data[THR_W-1:0];
                CFG_MIN_IVL:   min_reg   <= cfg_data;
                CFG_MAX_IVL:   max_reg   <= cfg_data;
                CFG_FLUSH_TMO: flush_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Slot memory and batch readout
    gsdb_emitter #(
        .BATCH_SLOTS (BATCH_SLOTS)
    ) u_emitter (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .wr                  (slot_wr),
        .wr_idx              (fill_reg[IW-1:0]),
        .start_batch         (accept && emit_now),
        .desc                (desc),
        .desc_fill           (fill_next),
        .busy                (emit_busy),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_first_step_number (m_first_step_number),
        .m_slot_period       (m_slot_period),
        .m_slot_intensity    (m_slot_intensity),
        .m_batch_temperature (m_batch_temperature),
        .m_partial_batch     (m_partial_batch),
        .m_last_of_batch     (m_last_of_batch)
    );

endmodule

// ----- tb/gsdb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsdb_checker
// Watches the sample, slot and register write channels of the step batcher,
// predicts every slot request from the accepted samples and compares each
// accepted slot request, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gsdb_checker #(
    parameter int NSLOTS = 5
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [gsdb_pkg::RATE_W-1:0]   s_rate_y,
    input  logic signed [gsdb_pkg::RATE_W-1:0]   s_rate_z,
    input  logic signed [gsdb_pkg::TEMP_W-1:0]   s_temperature_sample,
    input  logic [gsdb_pkg::TIME_W-1:0]          s_time_ms,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [gsdb_pkg::NUM_W-1:0]           m_first_step_number,
    input  logic [gsdb_pkg::PER_W-1:0]           m_slot_period,
    input  logic [gsdb_pkg::THR_W-1:0]           m_slot_intensity,
    input  logic signed [gsdb_pkg::TEMP_W-1:0]   m_batch_temperature,
    input  logic                                 m_partial_batch,
    input  logic                                 m_last_of_batch,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [gsdb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsdb_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   samples_seen,
    output int                                   results_seen,
    output int                                   full_batches,
    output int                                   partial_batches,
    output int                                   cfg_writes
);
    import gsdb_pkg::*;

    typedef struct {
        logic [NUM_W-1:0]         first_num;
        logic [PER_W-1:0]         period;
        logic [THR_W-1:0]         intensity;
        logic signed [TEMP_W-1:0] temp;
        logic                     partial;
        logic                     last;
    } slot_result_t;

    slot_result_t expected_slots[$];

    // Register copies
    logic [THR_W-1:0] rise_thr;
    logic [THR_W-1:0] fall_thr;
    logic [IVL_W-1:0] min_ivl;
    logic [IVL_W-1:0] max_ivl;
    logic [IVL_W-1:0] flush_tmo;

    // Detector and batch state
    logic             lock_set;
    logic [STEPS_W-1:0] step_total;
    logic [TIME_W-1:0]  stamp_ms;
    int               fill_count;
    logic [NUM_W-1:0] batch_first;
    logic [PER_W-1:0] slot_period_q [NSLOTS];
    logic [THR_W-1:0] slot_swing_q  [NSLOTS];

    // Queue one whole batch, padding unused slots with zeros
    function void queue_batch(input logic signed [TEMP_W-1:0] temp, input logic partial);
        slot_result_t r;
        int k;
        for (k = 0; k < NSLOTS; k++) begin
            r.first_num = batch_first;
            r.period    = (k < fill_count) ? slot_period_q[k] : '0;
            r.intensity = (k < fill_count) ? slot_swing_q[k] : '0;
            r.temp      = temp;
            r.partial   = partial;
            r.last      = (k == NSLOTS - 1);
            expected_slots.push_back(r);
        end
        fill_count = 0;
        if (partial)
            partial_batches++;
        else
            full_batches++;
    endfunction

    // Advance the detector by one sample
    task automatic predict_sample(input logic signed [RATE_W-1:0] gy,
                                  input logic signed [RATE_W-1:0] gz,
                                  input logic signed [TEMP_W-1:0] temp,
                                  input logic [TIME_W-1:0] now);
        int diff;
        int scaled;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] idle_ms;
        diff   = int'(gy) - int'(gz);
        scaled = 4 * ((diff < 0) ? -diff : diff);
        dt     = now - stamp_ms;
        if (scaled > int'(rise_thr) * 131 && !lock_set) begin
            lock_set = 1'b1;
            if ((dt >= TIME_W'(min_ivl) && dt <= TIME_W'(max_ivl)) || step_total == '0) begin
                step_total = step_total + 1;
                if (fill_count == 0)
                    batch_first = step_total[NUM_W-1:0];
                if (fill_count < NSLOTS) begin
                    slot_period_q[fill_count] = dt[PER_W-1:0];
                    slot_swing_q[fill_count]  = THR_W'(scaled / 131);
                    fill_count++;
                end
                stamp_ms = now;
                if (fill_count >= NSLOTS) begin
                    queue_batch(temp, 1'b0);
                    return;
                end
            end else if (dt > TIME_W'(max_ivl)) begin
                stamp_ms = now;
            end
        end else if (scaled < int'(fall_thr) * 131) begin
            lock_set = 1'b0;
        end
        idle_ms = now - stamp_ms;
        if (fill_count > 0 && idle_ms > TIME_W'(flush_tmo))
            queue_batch(temp, 1'b1);
    endtask

    function void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        slot_result_t want;
        if (!aresetn) begin
            rise_thr   = RISE_RST;
            fall_thr   = FALL_RST;
            min_ivl    = MIN_RST;
            max_ivl    = MAX_RST;
            flush_tmo  = FLUSH_RST;
            lock_set   = 1'b0;
            step_total = '0;
            stamp_ms   = '0;
            fill_count = 0;
            batch_first = '0;
            for (int k = 0; k < NSLOTS; k++) begin
                slot_period_q[k] = '0;
                slot_swing_q[k]  = '0;
            end
            expected_slots.delete();
        end else begin
            // Register write request
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_index)
                    CFG_RISE_THR:  rise_thr  = cfg_data[THR_W-1:0];
                    CFG_FALL_THR:  fall_thr  = cfg_data[THR_W-1:0];
                    CFG_MIN_IVL:   min_ivl   = cfg_data[IVL_W-1:0];
                    CFG_MAX_IVL:   max_ivl   = cfg_data[IVL_W-1:0];
                    CFG_FLUSH_TMO: flush_tmo = cfg_data[IVL_W-1:0];
                    default: ;
                endcase
            end
            // Slot request leaving the block
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_slots.size() == 0) begin
                    $error("slot request with no prediction pending");
                    fail_count++;
                end else begin
                    want = expected_slots.pop_front();
                    check_field("first_step_number", want.first_num, m_first_step_number);
                    check_field("slot_period", want.period, m_slot_period);
                    check_field("slot_intensity", want.intensity, m_slot_intensity);
                    check_field("batch_temperature", want.temp, m_batch_temperature);
                    check_field("partial_batch", want.partial, m_partial_batch);
                    check_field("last_of_batch", want.last, m_last_of_batch);
                end
            end
            // Sample request entering the block
            if (s_valid && s_ready) begin
                samples_seen++;
                predict_sample(s_rate_y, s_rate_z, s_temperature_sample, s_time_ms);
            end
        end
        pending = expected_slots.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives gyro samples and register writes into the step batcher, with random
// gaps and stalls, a long output hold-off and several threshold settings; the
// checker beside the block predicts and compares every slot request.
// ----------------------------------------------------------------------------
module tb_top;
    import gsdb_pkg::*;

    localparam int  SLOTS         = 5;
    localparam int  IDLE_PCT      = 25;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  SETTLE_CYCLES = 16;
    localparam real TIMEOUT_NS    = 10_000_000.0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [RATE_W-1:0] s_rate_y;
    logic signed [RATE_W-1:0] s_rate_z;
    logic signed [TEMP_W-1:0] s_temperature_sample;
    logic [TIME_W-1:0]        s_time_ms;
    logic                     m_valid;
    logic                     m_ready;
    logic [NUM_W-1:0]         m_first_step_number;
    logic [PER_W-1:0]         m_slot_period;
    logic [THR_W-1:0]         m_slot_intensity;
    logic signed [TEMP_W-1:0] m_batch_temperature;
    logic                     m_partial_batch;
    logic                     m_last_of_batch;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int fail_count, pending, samples_seen, results_seen;
    int full_batches, partial_batches, cfg_writes;

    // Stimulus-side view of the registers, used to aim the swings and intervals
    int cur_rise, cur_fall, cur_min, cur_max, cur_flush;
    logic [TIME_W-1:0] gen_peak;
    bit quiet;
    bit hold_req;

    gyro_step_detector_batcher #(
        .BATCH_SLOTS(SLOTS)
    ) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rate_y             (s_rate_y),
        .s_rate_z             (s_rate_z),
        .s_temperature_sample (s_temperature_sample),
        .s_time_ms            (s_time_ms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_first_step_number  (m_first_step_number),
        .m_slot_period        (m_slot_period),
        .m_slot_intensity     (m_slot_intensity),
        .m_batch_temperature  (m_batch_temperature),
        .m_partial_batch      (m_partial_batch),
        .m_last_of_batch      (m_last_of_batch),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    gsdb_checker #(
        .NSLOTS(SLOTS)
    ) u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rate_y             (s_rate_y),
        .s_rate_z             (s_rate_z),
        .s_temperature_sample (s_temperature_sample),
        .s_time_ms            (s_time_ms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_first_step_number  (m_first_step_number),
        .m_slot_period        (m_slot_period),
        .m_slot_intensity     (m_slot_intensity),
        .m_batch_temperature  (m_batch_temperature),
        .m_partial_batch      (m_partial_batch),
        .m_last_of_batch      (m_last_of_batch),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .fail_count           (fail_count),
        .pending              (pending),
        .samples_seen         (samples_seen),
        .results_seen         (results_seen),
        .full_batches         (full_batches),
        .partial_batches      (partial_batches),
        .cfg_writes           (cfg_writes)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Slot receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Smallest raw difference that counts as a rising edge
    function automatic int edge_level();
        int v;
        v = (cur_rise * 131) / 4 + 1;
        return (v > 65535) ? 65535 : v;
    endfunction

    // Largest raw difference that releases the lock; zero when the fall threshold is zero
    function automatic int release_level();
        if (cur_fall == 0)
            return 0;
        return (cur_fall * 131 + 3) / 4 - 1;
    endfunction

    // Offer one sample and hold it until accepted
    task automatic push_sample(input logic signed [RATE_W-1:0] y,
                               input logic signed [RATE_W-1:0] z,
                               input logic signed [TEMP_W-1:0] tp,
                               input logic [TIME_W-1:0] t);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid              <= 1'b1;
        s_rate_y             <= y;
        s_rate_z             <= z;
        s_temperature_sample <= tp;
        s_time_ms            <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Offer a sample whose raw rate difference is d, placed anywhere in range
    task automatic push_swing(input int d, input logic [TIME_W-1:0] t);
        int yv, zv, sw;
        zv = -32768 + int'($urandom_range(0, 65535 - d));
        yv = zv + d;
        if ($urandom_range(0, 1)) begin
            sw = yv;
            yv = zv;
            zv = sw;
        end
        push_sample(RATE_W'(yv), RATE_W'(zv), TEMP_W'($urandom), t);
    endtask

    // Drop valid, wait for every predicted slot, then let the block settle
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write; valid stays high until cfg_close
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_RISE_THR:  cur_rise  = int'(data[THR_W-1:0]);
            CFG_FALL_THR:  cur_fall  = int'(data[THR_W-1:0]);
            CFG_MIN_IVL:   cur_min   = int'(data[IVL_W-1:0]);
            CFG_MAX_IVL:   cur_max   = int'(data[IVL_W-1:0]);
            CFG_FLUSH_TMO: cur_flush = int'(data[IVL_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Load a full register set once the block is idle
    task automatic apply_setting(input logic [CFG_DATA_W-1:0] rise,
                                 input logic [CFG_DATA_W-1:0] fall,
                                 input logic [CFG_DATA_W-1:0] mn,
                                 input logic [CFG_DATA_W-1:0] mx,
                                 input logic [CFG_DATA_W-1:0] fl);
        wait_drained();
        cfg_write(CFG_RISE_THR, rise);
        cfg_write(CFG_FALL_THR, fall);
        cfg_write(CFG_MIN_IVL, mn);
        cfg_write(CFG_MAX_IVL, mx);
        cfg_write(CFG_FLUSH_TMO, fl);
        cfg_close();
    endtask

    // Hand-picked samples under the reset settings
    task automatic run_directed();
        int k;
        // first step counted although its interval is short
        push_sample(16'sh7FFF, -16'sh8000, -16'sh8000, 32'd100);
        push_sample(-16'sh8000, -16'sh8000, 16'sh7FFF, 32'd110);
        // edge with too short an interval only sets the lock
        push_sample(16'sd5732, 16'sd0, 16'sh0F0F, 32'd200);
        // lock held just above the release level, dropped just below
        push_sample(16'sd2457, 16'sd0, -16'sh5A5A, 32'd210);
        push_sample(16'sd2456, 16'sd0, 16'sh1234, 32'd220);
        // interval exactly at the lower bound, negative difference
        push_sample(-16'sh8000, 16'sh7FFF, 16'sh4321, 32'd350);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'd360);
        // swing one below the edge level
        push_sample(16'sd5731, 16'sd0, 16'sd77, 32'd500);
        // interval exactly at the upper bound
        push_sample(16'sd0, -16'sd5732, -16'sd1, 32'd2850);
        push_sample(16'sd0, 16'sd0, 16'sd5, 32'd2860);
        // idle time at the timeout, then one past it: partial batch
        push_sample(16'sd0, 16'sd0, 16'sd6, 32'd5350);
        push_sample(16'sd0, 16'sd0, -16'sd300, 32'd5351);
        // edge one past the upper bound restarts timing
        push_sample(16'sd6000, 16'sd0, 16'sd9, 32'd5351);
        push_sample(16'sd0, 16'sd0, 16'sd10, 32'd5360);
        // restart near the top of the tick, then five steps across the wrap
        push_sample(16'sd6000, 16'sd0, 16'sd11, 32'hFFFF_FE00);
        push_sample(16'sd0, 16'sd0, 16'sd12, 32'hFFFF_FE10);
        for (k = 1; k <= SLOTS; k++) begin
            push_sample(16'sd6000, -16'sd40, TEMP_W'($urandom), 32'hFFFF_FE00 + 32'(500 * k));
            if (k < SLOTS)
                push_sample(16'sd3, 16'sd0, TEMP_W'($urandom), 32'hFFFF_FE10 + 32'(500 * k));
        end
        gen_peak = 32'hFFFF_FE00 + 32'(500 * SLOTS);
    endtask

    // Mostly well-formed walking, with odd edges, pauses and noise mixed in
    task automatic run_walk(input int n, input bit good_only);
        int done_n, kind, ivl, mids, k;
        logic [TIME_W-1:0] t;
        done_n = 0;
        while (done_n < n) begin
            kind = good_only ? 0 : int'($urandom_range(0, 99));
            if (kind < 68) begin
                // step: edge, a few samples between the levels, release
                if (cur_min <= cur_max) begin
                    case ($urandom_range(0, 9))
                        0:       ivl = cur_min;
                        1:       ivl = cur_max;
                        default: ivl = rand_between(cur_min, cur_max);
                    endcase
                end else begin
                    ivl = rand_between(0, 3000);
                end
                gen_peak = gen_peak + 32'(ivl);
                push_swing(rand_between(edge_level(), 65535), gen_peak);
                mids = (release_level() + 1 < edge_level()) ? int'($urandom_range(0, 2)) : 0;
                for (k = 0; k < mids; k++)
                    push_swing(rand_between(release_level() + 1, edge_level() - 1),
                               gen_peak + 32'(k * 5 + 1));
                push_swing(rand_between(0, release_level()), gen_peak + 32'd20);
                done_n += 2 + mids;
            end else if (kind < 78) begin
                // edge too early, or after a long pause
                if (cur_min > 0 && $urandom_range(0, 1)) begin
                    t = gen_peak + 32'(rand_between(0, cur_min - 1));
                end else begin
                    t = gen_peak + 32'(cur_max + 1 + rand_between(0, 3000));
                    gen_peak = t;
                end
                push_swing(rand_between(edge_level(), 65535), t);
                push_swing(rand_between(0, release_level()), t + 32'd20);
                done_n += 2;
            end else if (kind < 88) begin
                // quiet samples at and past the flush timeout
                push_swing(rand_between(0, release_level()), gen_peak + 32'(cur_flush));
                push_swing(rand_between(0, release_level()),
                           gen_peak + 32'(cur_flush + 1 + rand_between(0, 200)));
                done_n += 2;
            end else begin
                // noise on every field
                t = $urandom_range(0, 1) ? TIME_W'($urandom)
                                         : gen_peak + 32'(rand_between(0, 100));
                push_sample(RATE_W'($urandom), RATE_W'($urandom), TEMP_W'($urandom), t);
                done_n += 1;
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        int rr, ff, mn;
        aresetn              = 1'b0;
        s_valid              = 1'b0;
        s_rate_y             = '0;
        s_rate_z             = '0;
        s_temperature_sample = '0;
        s_time_ms            = '0;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        quiet                = 1'b0;
        hold_req             = 1'b0;
        cur_rise  = int'(RISE_RST);
        cur_fall  = int'(FALL_RST);
        cur_min   = int'(MIN_RST);
        cur_max   = int'(MAX_RST);
        cur_flush = int'(FLUSH_RST);
        gen_peak  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_walk(80, 1'b0);

        // Reset values rewritten, rise threshold with junk in the upper bits;
        // then hold the output off while samples keep coming, no gaps anywhere
        apply_setting(16'hF800 | CFG_DATA_W'(RISE_RST), CFG_DATA_W'(FALL_RST),
                      MIN_RST, MAX_RST, FLUSH_RST);
        quiet    = 1'b1;
        hold_req = 1'b1;
        run_walk(60, 1'b1);
        quiet = 1'b0;
        wait_drained();
        run_walk(20, 1'b0);

        // Top of every range, plus a write to an unmapped index
        apply_setting(16'd2001, 16'd2001, 16'd0, 16'hFFFF, 16'hFFFF);
        cfg_write(CFG_UNMAPPED, 16'hFFFF);
        cfg_close();
        gen_peak = $urandom;
        run_walk(50, 1'b0);

        // Bottom of every range: zero interval only, flush on any time change
        apply_setting(16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        run_walk(40, 1'b0);

        // Lock that can never be released
        apply_setting(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd1000);
        run_walk(10, 1'b0);

        // Interval bounds crossed
        apply_setting(16'd300, 16'd100, 16'd3000, 16'd100, 16'd500);
        run_walk(30, 1'b0);

        // Random settings
        repeat (3) begin
            rr = rand_between(20, 600);
            ff = rand_between(0, rr);
            mn = rand_between(0, 500);
            apply_setting(CFG_DATA_W'(rr), CFG_DATA_W'(ff), CFG_DATA_W'(mn),
                          CFG_DATA_W'(mn + rand_between(0, 3000)),
                          CFG_DATA_W'(rand_between(0, 4000)));
            gen_peak = $urandom;
            run_walk(50, 1'b0);
        end

        wait_drained();
        $display("Run covered %0d samples and %0d slot requests (%0d full, %0d partial).",
                 samples_seen, results_seen, full_batches, partial_batches);
        $display("Settings: reset, range extremes, stuck lock, crossed bounds, random; %0d writes.",
                 cfg_writes);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
